FILE: rtl/lmas_pkg.sv
`timescale 1ns / 1ps
package lmas_pkg;

  // Fixed matrix geometry and register reset values
  localparam int MATRIX_COLUMNS    = 8;
  localparam int STORE_BYTES_DEF   = 512;
  localparam logic [15:0] COLUMN_DIVIDER_RST = 16'd10;
  localparam logic [15:0] FRAME_DIVIDER_RST  = 16'd1250;
  localparam logic [6:0]  FRAME_COUNT_RST    = 7'd35;
  localparam logic [6:0]  FRAME_INDEX_MAX    = 7'd63;

  // Input item kinds
  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_LOAD = 1'b1
  } kind_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_COLUMN_DIVIDER = 2'd0,
    CFG_FRAME_DIVIDER  = 2'd1,
    CFG_FRAME_COUNT    = 2'd2
  } cfg_index_t;

  typedef struct packed {
    kind_t       kind;
    logic [8:0]  load_index;
    logic [7:0]  load_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  row_bits;
    logic [7:0]  column_select;
    logic [5:0]  frame_shown;
  } out_item_t;

  // Column drive issued alongside a store read
  typedef struct packed {
    logic        valid;
    logic        rows_zero;
    logic [7:0]  column_select;
    logic [5:0]  frame_shown;
  } issue_t;

endpackage

FILE: rtl/lmas_ram.sv
`timescale 1ns / 1ps
module lmas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, registered read port that holds when idle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/lmas_sched.sv
`timescale 1ns / 1ps
module lmas_sched import lmas_pkg::*; #(
  parameter int STORE_BYTES = STORE_BYTES_DEF,
  localparam int AW = $clog2(STORE_BYTES)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  in_item_t      item,
  input  logic          cfg_write,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  output issue_t        issue,
  output logic          ram_we,
  output logic [AW-1:0] ram_waddr,
  output logic [7:0]    ram_wdata,
  output logic          ram_re,
  output logic [AW-1:0] ram_raddr
);

  logic [15:0] column_divider;
  logic [15:0] frame_divider;
  logic [6:0]  frame_count;
  logic [15:0] column_tick_count;
  logic [15:0] frame_tick_count;
  logic        column_pending;
  logic [2:0]  column_index;
  logic [5:0]  next_frame_index;
  logic [5:0]  shown_frame_index;
  logic        shown_valid;

  logic        tick;
  logic [15:0] column_tick_next;
  logic [15:0] frame_tick_next;
  logic        column_fire;
  logic        frame_fire;
  logic [6:0]  frame_inc;
  logic [5:0]  next_frame_next;
  logic [5:0]  shown_frame_next;
  logic        shown_valid_next;
  logic        pending_next;
  logic [8:0]  rd_addr;
  logic        rd_in_range;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      column_divider <= COLUMN_DIVIDER_RST;
      frame_divider  <= FRAME_DIVIDER_RST;
      frame_count    <= FRAME_COUNT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_COLUMN_DIVIDER: column_divider <= cfg_data;
        CFG_FRAME_DIVIDER:  frame_divider  <= cfg_data;
        CFG_FRAME_COUNT:    frame_count    <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Tick dividers, frame advance, then column drive
  always_comb begin
    tick             = accept && (item.kind == KIND_TICK);
    column_tick_next = column_tick_count + 16'd1;
    column_fire      = (column_tick_next >= column_divider) || (column_tick_next == 16'd0);
    frame_tick_next  = frame_tick_count + 16'd1;
    frame_fire       = (frame_tick_next >= frame_divider) || (frame_tick_next == 16'd0);
    frame_inc        = {1'b0, next_frame_index} + 7'd1;
    if ((frame_inc >= frame_count) || (frame_inc > FRAME_INDEX_MAX)) begin
      next_frame_next = 6'd0;
    end else begin
      next_frame_next = frame_inc[5:0];
    end
    shown_frame_next = frame_fire ? next_frame_index : shown_frame_index;
    shown_valid_next = frame_fire || shown_valid;
    pending_next     = column_pending || column_fire;
    rd_addr          = {shown_frame_next, column_index};
    rd_in_range      = 32'(rd_addr) < STORE_BYTES;
  end

  // Issue the column drive and its store read
  always_comb begin
    issue.valid         = tick && pending_next;
    issue.rows_zero     = !shown_valid_next || !rd_in_range;
    issue.column_select = 8'b1 << column_index;
    issue.frame_shown   = shown_frame_next;
    ram_re              = issue.valid;
    ram_raddr           = AW'(rd_addr);
    ram_we              = accept && (item.kind == KIND_LOAD) &&
                          (32'(item.load_index) < STORE_BYTES);
    ram_waddr           = AW'(item.load_index);
    ram_wdata           = item.load_byte;
  end

  // Advance counters and flags on each tick
  always_ff @(posedge clk) begin
    if (rst) begin
      column_tick_count <= '0;
      frame_tick_count  <= '0;
      column_pending    <= 1'b1;
      column_index      <= '0;
      next_frame_index  <= '0;
      shown_frame_index <= '0;
      shown_valid       <= 1'b0;
    end else if (tick) begin
      column_tick_count <= column_fire ? 16'd0 : column_tick_next;
      frame_tick_count  <= frame_fire ? 16'd0 : frame_tick_next;
      if (frame_fire) begin
        next_frame_index <= next_frame_next;
      end
      shown_frame_index <= shown_frame_next;
      shown_valid       <= shown_valid_next;
      column_pending    <= !issue.valid && pending_next;
      if (issue.valid) begin
        column_index <= column_index + 3'd1;
      end
    end
  end

  // A drive always steps the column by one
  a_col_step: assert property (@(posedge clk) disable iff (rst)
    issue.valid |=> column_index == $past(column_index) + 3'd1)
    else $error("column index did not step after a drive");

  // A drive consumes the pending flag
  a_pending_clear: assert property (@(posedge clk) disable iff (rst)
    issue.valid |=> !column_pending)
    else $error("pending flag survived a drive");

endmodule

FILE: rtl/lmas_out.sv
`timescale 1ns / 1ps
module lmas_out import lmas_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  issue_t     issue,
  input  logic [7:0] ram_rdata,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data
);

  logic   s1_valid;
  issue_t s1_meta;
  logic   s1_move;

  // Read stage waits for store data; output register parts it from the sink
  always_comb begin
    s1_move  = s1_valid && (!out_valid || out_ready);
    in_ready = !s1_valid || !out_valid || out_ready;
  end

  // Hold the issued drive while its store read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept && issue.valid) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && issue.valid) begin
      s1_meta <= issue;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data.row_bits      <= s1_meta.rows_zero ? 8'd0 : ram_rdata;
      out_data.column_select <= s1_meta.column_select;
      out_data.frame_shown   <= s1_meta.frame_shown;
    end
  end

  // A stalled read stage must block new items so the store data is not lost
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_move) |-> !in_ready)
    else $error("input taken while read stage stalled");

  // Every delivered result selects exactly one column
  a_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot(out_data.column_select))
    else $error("column select not one-hot");

endmodule

FILE: rtl/led_matrix_animation_scanner_core.sv
`timescale 1ns / 1ps
// A column drive passes the read stage, then the output register. Throughput:
// one item (tick or store load) per cycle while in_ready is high; the store
// has one write and one registered read port; dividers update in the transfer cycle.
// Reset (rst, synchronous): dividers 10 / 1250, frame count 35, counters zero,
// column pending set, pipeline empty. The frame store is not cleared.
module led_matrix_animation_scanner_core import lmas_pkg::*; #(
  parameter int STORE_BYTES = STORE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW = $clog2(STORE_BYTES);

  logic          accept;
  issue_t        issue;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  lmas_sched #(
    .STORE_BYTES(STORE_BYTES)
  ) u_sched (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (in_data),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .issue     (issue),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr)
  );

  lmas_ram #(
    .WIDTH(8),
    .DEPTH(STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lmas_out u_out (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .issue     (issue),
    .ram_rdata (ram_rdata),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
